[src/dls_pkg.sv]
package dls_pkg;

  // Command opcodes recognized by the sequencer.
  localparam logic [7:0] OP_NOP        = 8'h00;
  localparam logic [7:0] OP_VADDR      = 8'h01;
  localparam logic [7:0] OP_IADDR      = 8'h02;
  localparam logic [7:0] OP_JUMP       = 8'h08;
  localparam logic [7:0] OP_CALL       = 8'h0A;
  localparam logic [7:0] OP_RET        = 8'h0B;
  localparam logic [7:0] OP_END        = 8'h0C;
  localparam logic [7:0] OP_SIGNAL     = 8'h0E;
  localparam logic [7:0] OP_FINISH     = 8'h0F;
  localparam logic [7:0] OP_BASE       = 8'h10;
  localparam logic [7:0] OP_FINISH_ALT = 8'h11;
  localparam logic [7:0] OP_WMS        = 8'h3A;
  localparam logic [7:0] OP_VMS        = 8'h3C;
  localparam logic [7:0] OP_PMS        = 8'h3E;
  localparam logic [7:0] OP_TMS        = 8'h40;

  // List status codes.
  localparam logic [2:0] ST_RUNNING   = 3'd0;
  localparam logic [2:0] ST_STALLED   = 3'd1;
  localparam logic [2:0] ST_PAUSED    = 3'd2;
  localparam logic [2:0] ST_DONE      = 3'd3;
  localparam logic [2:0] ST_STACK_ERR = 3'd4;

  // Matrix slot codes.
  localparam logic [2:0] MX_NONE  = 3'd0;
  localparam logic [2:0] MX_PROJ  = 3'd1;
  localparam logic [2:0] MX_VIEW  = 3'd2;
  localparam logic [2:0] MX_WORLD = 3'd3;
  localparam logic [2:0] MX_TEX   = 3'd4;

  localparam logic [4:0] MX_LEN_PROJ  = 5'd16;
  localparam logic [4:0] MX_LEN_OTHER = 5'd12;

  // Configuration register indexes.
  localparam logic REG_START = 1'b0;
  localparam logic REG_STALL = 1'b1;

  localparam logic [31:0] ALIGN_MASK = 32'hFFFF_FFFC;

  // Control from the sequencer to the return stack.
  typedef struct packed {
    logic clear;
    logic push;
    logic pop;
  } stack_ctrl_t;

  // One result item.
  typedef struct packed {
    logic [3:0]  matrix_index;
    logic [2:0]  matrix_slot;
    logic [31:0] effective_address;
    logic [23:0] forward_argument;
    logic [7:0]  forward_command;
    logic        forward_valid;
    logic [2:0]  list_status;
    logic [31:0] fetch_address;
  } result_t;

endpackage

[src/dls_stack.sv]
module dls_stack #(
  parameter int STACK_DEPTH = 8,
  parameter int LVL_W       = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dls_pkg::stack_ctrl_t ctrl_i,
  input  logic [31:0]          push_data_i,
  output logic [LVL_W-1:0]     level_o,
  output logic [31:0]          top_o
);
  import dls_pkg::*;

  localparam int PTR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  // The top entry and the one below it live in registers so that a return
  // sees its address at once; deeper entries sit in the array, whose read
  // is registered into the second-entry register on each pop.
  logic [31:0]      mem_q [STACK_DEPTH];
  logic [31:0]      top_q;
  logic [31:0]      second_q;
  logic [LVL_W-1:0] level_q;
  logic [LVL_W-1:0] lvl_m1;
  logic [LVL_W-1:0] lvl_m3;

  assign lvl_m1 = level_q - LVL_W'(1);
  assign lvl_m3 = level_q - LVL_W'(3);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= '0;
    end else if (ctrl_i.clear) begin
      level_q <= '0;
    end else if (ctrl_i.push) begin
      level_q <= level_q + LVL_W'(1);
    end else if (ctrl_i.pop) begin
      level_q <= lvl_m1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!ctrl_i.clear && ctrl_i.push) begin
      top_q    <= push_data_i;
      second_q <= top_q;
      if (level_q != '0) begin
        mem_q[lvl_m1[PTR_W-1:0]] <= top_q;
      end
    end else if (!ctrl_i.clear && ctrl_i.pop) begin
      top_q <= second_q;
      if (level_q >= LVL_W'(3)) begin
        second_q <= mem_q[lvl_m3[PTR_W-1:0]];
      end
    end
  end

  assign level_o = level_q;
  assign top_o   = top_q;

`ifndef NO_ASSERTIONS
  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    level_q <= LVL_W'(STACK_DEPTH))
    else $error("return stack level beyond depth");

  a_push_pop_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctrl_i.push && ctrl_i.pop))
    else $error("push and pop requested together");
`endif

endmodule

[src/display_list_sequencer.sv]
// Display-list sequencer.
// Input channel (s_axis_*): one command packet per transfer, command byte in
// tdata[7:0] and 24-bit argument in tdata[31:8]. Each packet yields exactly
// one result transfer on the output channel (m_axis_*), carrying the next
// fetch address, the list status, the packet forwarded to the render back
// end, the effective address and the matrix element tag.
// Configuration channel (cfg_*): register 0 is the list start address (a
// write reloads the pointer and clears the return stack, NOP run, finish
// flag and any matrix load), register 1 is the stall address. It is always
// ready and should only be written while no result is outstanding.
// The result of a packet accepted at one edge is shown on the output
// register after that edge. Throughput is one packet per cycle unless the
// receiver stalls; the return stack keeps its top two entries in
// registers so CALL and RET also run at full rate.
// If the receiver stalls, the output register holds its result and the input
// is still taken in the cycle the held result is transferred out.
// Reset clears the pointer, base register, stack level, counters, the stall
// address and the output valid flag.
module display_list_sequencer #(
  parameter int STACK_DEPTH = 8,
  parameter int NOP_LIMIT   = 10
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  // Configuration write channel.
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic          cfg_index_i,
  input  logic [31:0]   cfg_data_i,
  // Command packets in.
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [31:0]   s_axis_tdata,  // command[7:0], argument[31:8]
  // Results out.
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // fetch_address[31:0], list_status[34:32], forward_valid[35],
  // forward_command[43:36], forward_argument[67:44], effective_address[99:68],
  // matrix_slot[102:100], matrix_index[106:103], zero fill [111:107]
  output logic [111:0]  m_axis_tdata
);
  import dls_pkg::*;

  localparam int LVL_W = $clog2(STACK_DEPTH + 1);

  logic in_acc;
  logic cfg_start;
  logic cfg_stall;

  logic [31:0] fetch_ptr_q, fetch_ptr_d;
  logic [31:0] base_q, base_d;
  logic [31:0] stall_q;
  logic [3:0]  nop_run_q, nop_run_d;
  logic        finish_q, finish_d;
  logic [2:0]  mx_kind_q, mx_kind_d;
  logic [4:0]  mx_left_q, mx_left_d;

  logic             out_valid_q;
  result_t          out_q, res;
  stack_ctrl_t      stk_ctrl;
  logic [LVL_W-1:0] stk_level;
  logic [31:0]      stk_top;

  logic [7:0]  cmd;
  logic [23:0] arg;
  logic [31:0] seq_addr;
  logic [31:0] ea_raw;
  logic [4:0]  mx_total;

  assign cmd = s_axis_tdata[7:0];
  assign arg = s_axis_tdata[31:8];

  assign cfg_ready_o   = 1'b1;
  assign cfg_start     = cfg_valid_i && (cfg_index_i == REG_START);
  assign cfg_stall     = cfg_valid_i && (cfg_index_i == REG_STALL);
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  assign seq_addr = fetch_ptr_q + 32'd4;
  assign ea_raw   = base_q | {8'd0, arg};
  assign mx_total = (mx_kind_q == MX_PROJ) ? MX_LEN_PROJ : MX_LEN_OTHER;

  dls_stack #(
    .STACK_DEPTH (STACK_DEPTH),
    .LVL_W       (LVL_W)
  ) u_stack (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (stk_ctrl),
    .push_data_i (seq_addr),
    .level_o     (stk_level),
    .top_o       (stk_top)
  );

  // Packet decode and next-state logic.
  always_comb begin
    logic [4:0] mx_pos;

    mx_pos           = mx_total - mx_left_q;
    res              = '0;
    res.fetch_address = seq_addr;
    res.list_status  = ST_RUNNING;
    fetch_ptr_d      = seq_addr;
    base_d           = base_q;
    nop_run_d        = nop_run_q;
    finish_d         = finish_q;
    mx_kind_d        = mx_kind_q;
    mx_left_d        = mx_left_q;
    stk_ctrl         = '0;

    if (fetch_ptr_q == stall_q) begin
      // Fetch is held at the stall address; the packet is dropped.
      res.list_status   = ST_STALLED;
      res.fetch_address = fetch_ptr_q;
      fetch_ptr_d       = fetch_ptr_q;
    end else if (mx_left_q != 5'd0) begin
      // Matrix element: passed on whatever its command byte.
      res.forward_valid    = 1'b1;
      res.forward_command  = cmd;
      res.forward_argument = arg;
      res.matrix_slot      = mx_kind_q;
      res.matrix_index     = mx_pos[3:0];
      mx_left_d            = mx_left_q - 5'd1;
      if (mx_left_q == 5'd1) begin
        mx_kind_d = MX_NONE;
      end
    end else if (cmd == OP_NOP) begin
      if (nop_run_q >= 4'(NOP_LIMIT)) begin
        nop_run_d       = 4'(NOP_LIMIT);
        res.list_status = ST_DONE;
      end else begin
        nop_run_d = nop_run_q + 4'd1;
      end
    end else begin
      nop_run_d = 4'd0;
      case (cmd)
        OP_JUMP: begin
          res.effective_address = ea_raw;
          fetch_ptr_d           = ea_raw & ALIGN_MASK;
        end
        OP_CALL: begin
          res.effective_address = ea_raw;
          if (stk_level >= LVL_W'(STACK_DEPTH)) begin
            res.list_status = ST_STACK_ERR;
          end else begin
            stk_ctrl.push = 1'b1;
            fetch_ptr_d   = ea_raw & ALIGN_MASK;
          end
        end
        OP_RET: begin
          if (stk_level == '0) begin
            res.list_status = ST_STACK_ERR;
          end else begin
            stk_ctrl.pop = 1'b1;
            fetch_ptr_d  = stk_top;
          end
        end
        OP_END: begin
          res.list_status = finish_q ? ST_DONE : ST_PAUSED;
        end
        OP_FINISH, OP_FINISH_ALT: begin
          finish_d = 1'b1;
        end
        OP_SIGNAL: begin
          res.list_status = ST_RUNNING;
        end
        OP_BASE: begin
          base_d = {arg, 8'd0};
        end
        default: begin
          res.forward_valid    = 1'b1;
          res.forward_command  = cmd;
          res.forward_argument = arg;
          if (cmd == OP_VADDR || cmd == OP_IADDR) begin
            res.effective_address = ea_raw;
          end else if (cmd == OP_PMS) begin
            mx_kind_d = MX_PROJ;
            mx_left_d = MX_LEN_PROJ;
          end else if (cmd == OP_VMS) begin
            mx_kind_d = MX_VIEW;
            mx_left_d = MX_LEN_OTHER;
          end else if (cmd == OP_WMS) begin
            mx_kind_d = MX_WORLD;
            mx_left_d = MX_LEN_OTHER;
          end else if (cmd == OP_TMS) begin
            mx_kind_d = MX_TEX;
            mx_left_d = MX_LEN_OTHER;
          end
        end
      endcase
    end
    res.fetch_address = (fetch_ptr_q == stall_q) ? fetch_ptr_q : fetch_ptr_d;

    // Stack changes only take effect for an accepted packet; a start write
    // empties the stack.
    if (!in_acc) begin
      stk_ctrl.push = 1'b0;
      stk_ctrl.pop  = 1'b0;
    end
    stk_ctrl.clear = cfg_start;
  end

  // Sequencer state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fetch_ptr_q <= '0;
      base_q      <= '0;
      stall_q     <= '0;
      nop_run_q   <= '0;
      finish_q    <= 1'b0;
      mx_kind_q   <= MX_NONE;
      mx_left_q   <= '0;
    end else begin
      if (cfg_start) begin
        fetch_ptr_q <= cfg_data_i & ALIGN_MASK;
        nop_run_q   <= '0;
        finish_q    <= 1'b0;
        mx_kind_q   <= MX_NONE;
        mx_left_q   <= '0;
      end else if (in_acc) begin
        fetch_ptr_q <= fetch_ptr_d;
        base_q      <= base_d;
        nop_run_q   <= nop_run_d;
        finish_q    <= finish_d;
        mx_kind_q   <= mx_kind_d;
        mx_left_q   <= mx_left_d;
      end
      if (cfg_stall) begin
        stall_q <= cfg_data_i;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, out_q};

`ifndef NO_ASSERTIONS
  a_fwd_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !out_q.forward_valid) |->
      (out_q.forward_command == 8'd0 && out_q.forward_argument == 24'd0))
    else $error("dropped packet carries forwarded payload");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !cfg_valid_i && fetch_ptr_q == stall_q) |=>
      (fetch_ptr_q == $past(fetch_ptr_q) && out_q.list_status == ST_STALLED))
    else $error("pointer moved while stalled");

  a_matrix_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mx_left_q != 5'd0) |-> (mx_kind_q != MX_NONE && mx_left_q <= MX_LEN_PROJ))
    else $error("matrix countdown without a matrix kind");

  a_ptr_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fetch_ptr_q[1:0] == 2'b00)
    else $error("fetch pointer not word aligned");
`endif

endmodule

[dv/display_list_sequencer_tb.sv]
`timescale 1ns / 1ps

// Testbench for the display-list sequencer. Packets go in on the slave stream,
// one result comes back per packet on the master stream, and a tracker object
// predicts every result from its own copy of the pointer, base register,
// return stack and counters.
module display_list_sequencer_tb;
  import dls_pkg::*;

  localparam int STACK_DEPTH  = 8;
  localparam int NOP_LIMIT    = 10;
  // Random traffic stops once this many packets were accepted, stalled or not.
  localparam int ITEM_TARGET  = 380;
  // Least number of packets sent between two configuration changes.
  localparam int SEG_ITEMS    = 32;
  // Length of the one long receiver hold-off that backs the block up.
  localparam int HOLD_CYCLES  = 150;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int REPORT_LIMIT = 10;

  // Shapes of packet sequences used by the random part.
  typedef enum int {
    SEQ_MATRIX,
    SEQ_CALLS,
    SEQ_NOPS,
    SEQ_ENDING,
    SEQ_ADDRESS,
    SEQ_NOISE,
    SEQ_COUNT
  } seq_kind_e;

  // Keeps the sequencer state as the block should see it and the queue of
  // results that accepted packets still owe.
  class list_tracker;
    logic [31:0] fetch_ptr;
    logic [31:0] base_reg;
    logic [31:0] stall_addr;
    logic [31:0] ret_stack [STACK_DEPTH];
    int unsigned stack_used;
    int unsigned nop_count;
    bit          finished;
    logic [2:0]  mx_kind;
    int unsigned mx_left;
    result_t     pending_results[$];
    int          packet_count;
    int          failures;

    function new();
      fetch_ptr    = '0;
      base_reg     = '0;
      stall_addr   = '0;
      stack_used   = 0;
      nop_count    = 0;
      finished     = 1'b0;
      mx_kind      = MX_NONE;
      mx_left      = 0;
      packet_count = 0;
      failures     = 0;
    endfunction

    function void apply_write(logic idx, logic [31:0] value);
      if (idx == REG_START) begin
        fetch_ptr  = value & ALIGN_MASK;
        stack_used = 0;
        nop_count  = 0;
        finished   = 1'b0;
        mx_kind    = MX_NONE;
        mx_left    = 0;
      end else begin
        stall_addr = value;
      end
    endfunction

    // Executes one accepted packet and queues the result it must produce.
    function void note_packet(logic [7:0] cmd, logic [23:0] arg);
      result_t     r;
      logic [31:0] next_ptr;
      logic [31:0] ea_val;
      logic [31:0] target;
      r        = '0;
      next_ptr = fetch_ptr + 32'd4;
      ea_val   = base_reg | {8'h00, arg};
      target   = ea_val & ALIGN_MASK;
      packet_count++;
      if (fetch_ptr == stall_addr) begin
        // A stalled packet is dropped and nothing moves.
        r.list_status = ST_STALLED;
        next_ptr      = fetch_ptr;
      end else begin
        if (mx_left != 0) begin
          // Matrix elements are forwarded whatever their command byte.
          r.forward_valid    = 1'b1;
          r.forward_command  = cmd;
          r.forward_argument = arg;
          r.matrix_slot      = mx_kind;
          r.matrix_index     = 4'(((mx_kind == MX_PROJ) ? MX_LEN_PROJ : MX_LEN_OTHER) - mx_left);
          mx_left--;
          if (mx_left == 0) mx_kind = MX_NONE;
        end else if (cmd == OP_NOP) begin
          if (nop_count >= NOP_LIMIT) begin
            nop_count     = NOP_LIMIT;
            r.list_status = ST_DONE;
          end else begin
            nop_count++;
          end
        end else begin
          nop_count = 0;
          case (cmd)
            OP_JUMP: begin
              r.effective_address = ea_val;
              next_ptr            = target;
            end
            OP_CALL: begin
              r.effective_address = ea_val;
              if (stack_used >= STACK_DEPTH) begin
                r.list_status = ST_STACK_ERR;
              end else begin
                ret_stack[stack_used] = next_ptr;
                stack_used++;
                next_ptr = target;
              end
            end
            OP_RET: begin
              if (stack_used == 0) begin
                r.list_status = ST_STACK_ERR;
              end else begin
                stack_used--;
                next_ptr = ret_stack[stack_used];
              end
            end
            OP_END:                   r.list_status = finished ? ST_DONE : ST_PAUSED;
            OP_FINISH, OP_FINISH_ALT: finished = 1'b1;
            OP_SIGNAL:                ;
            OP_BASE:                  base_reg = {arg, 8'h00};
            default: begin
              r.forward_valid    = 1'b1;
              r.forward_command  = cmd;
              r.forward_argument = arg;
              if (cmd == OP_VADDR || cmd == OP_IADDR) begin
                r.effective_address = ea_val;
              end else if (cmd == OP_PMS) begin
                mx_kind = MX_PROJ;
                mx_left = MX_LEN_PROJ;
              end else if (cmd == OP_VMS) begin
                mx_kind = MX_VIEW;
                mx_left = MX_LEN_OTHER;
              end else if (cmd == OP_WMS) begin
                mx_kind = MX_WORLD;
                mx_left = MX_LEN_OTHER;
              end else if (cmd == OP_TMS) begin
                mx_kind = MX_TEX;
                mx_left = MX_LEN_OTHER;
              end
            end
          endcase
        end
      end
      fetch_ptr       = next_ptr;
      r.fetch_address = next_ptr;
      pending_results.push_back(r);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        failures++;
        if (failures <= REPORT_LIMIT)
          $display("ERROR: result transfer with no packet outstanding, fetch_address %h",
                   got.fetch_address);
        return;
      end
      want = pending_results.pop_front();
      if (got.fetch_address !== want.fetch_address ||
          got.list_status !== want.list_status ||
          got.forward_valid !== want.forward_valid ||
          got.forward_command !== want.forward_command ||
          got.forward_argument !== want.forward_argument ||
          got.effective_address !== want.effective_address ||
          got.matrix_slot !== want.matrix_slot ||
          got.matrix_index !== want.matrix_index) begin
        failures++;
        if (failures <= REPORT_LIMIT) begin
          $display("ERROR: result mismatch at %0t", $realtime);
          $display("  expected addr %h status %0d fwd %b cmd %h arg %h ea %h slot %0d idx %0d",
                   want.fetch_address, want.list_status, want.forward_valid,
                   want.forward_command, want.forward_argument, want.effective_address,
                   want.matrix_slot, want.matrix_index);
          $display("  actual   addr %h status %0d fwd %b cmd %h arg %h ea %h slot %0d idx %0d",
                   got.fetch_address, got.list_status, got.forward_valid,
                   got.forward_command, got.forward_argument, got.effective_address,
                   got.matrix_slot, got.matrix_index);
        end
      end
    endfunction
  endclass

  logic         clk_i;
  logic         rst_ni;
  logic         cfg_valid_i;
  logic         cfg_ready_o;
  logic         cfg_index_i;
  logic [31:0]  cfg_data_i;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [31:0]  s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [111:0] m_axis_tdata;

  list_tracker tracker;

  // Idle percentages of both sides; changed only while the stream is quiet.
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          sent_in_seg   = 0;
  logic        hold_req      = 1'b0;
  int          hold_count    = 0;
  int unsigned cycle_count   = 0;

  display_list_sequencer #(
    .STACK_DEPTH(STACK_DEPTH),
    .NOP_LIMIT  (NOP_LIMIT)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #1 clk_i = ~clk_i;

  // Both streams are sampled at the clock edge, before any driver update of
  // that edge takes effect. The packet is noted before the result is checked,
  // although the result is registered, so it never belongs to the packet
  // of the same edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        tracker.note_packet(s_axis_tdata[7:0], s_axis_tdata[31:8]);
      if (m_axis_tvalid && m_axis_tready)
        tracker.check_result(result_t'(m_axis_tdata[106:0]));
    end
  end

  // Receiver. Once hold_req is raised it refuses results until hold_count
  // reaches HOLD_CYCLES, a single time, so the output register fills up and the
  // block has to push back on its input; otherwise it stalls at random.
  always @(posedge clk_i) begin
    if (hold_req && hold_count < HOLD_CYCLES) begin
      m_axis_tready <= 1'b0;
      hold_count    <= hold_count + 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("ERROR: timeout after %0d cycles", CYCLE_LIMIT);
      $display("Verification failed");
      $finish;
    end
  end

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct <= send_pct;
    recv_idle_pct <= recv_pct;
  endtask

  // Offers one packet and returns at the edge where it is accepted. Valid is
  // left high so the next packet can follow back to back; it is only lowered
  // when the sender decides to idle.
  task automatic send_packet(input logic [7:0] cmd, input logic [23:0] arg);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {arg, cmd};
    sent_in_seg++;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Waits until every accepted packet has produced its result through the
  // output register.
  task automatic drain();
    repeat (2) @(posedge clk_i);
    while (tracker.pending_results.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] value);
    s_axis_tvalid <= 1'b0;
    drain();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    tracker.apply_write(idx, value);
  endtask

  function automatic logic [7:0] pick_matrix();
    case ($urandom_range(3))
      0:       return OP_PMS;
      1:       return OP_VMS;
      2:       return OP_WMS;
      default: return OP_TMS;
    endcase
  endfunction

  // Mostly known opcodes so that control commands turn up often inside other
  // sequences, the rest any byte at all.
  function automatic logic [7:0] pick_command();
    case ($urandom_range(15))
      0:       return OP_NOP;
      1:       return OP_VADDR;
      2:       return OP_IADDR;
      3:       return OP_JUMP;
      4:       return OP_CALL;
      5:       return OP_RET;
      6:       return OP_END;
      7:       return OP_SIGNAL;
      8:       return OP_FINISH;
      9:       return OP_BASE;
      10:      return OP_FINISH_ALT;
      11:      return pick_matrix();
      default: return 8'($urandom);
    endcase
  endfunction

  // Sends one sequence of the given shape. With worst set, the sequence runs
  // into the corner it is built for: a full projection load, a stack overflow
  // and underflow, a NOP run past the limit.
  task automatic send_sequence(input seq_kind_e kind, input bit worst);
    int count;
    case (kind)
      SEQ_MATRIX: begin
        send_packet(worst ? OP_PMS : pick_matrix(), 24'($urandom));
        // Now and then fewer packets follow, so the load may run on into the next sequence.
        count = (!worst && $urandom_range(9) == 0) ? $urandom_range(1, 15) : 16;
        repeat (count) send_packet(pick_command(), 24'($urandom));
      end
      SEQ_CALLS: begin
        count = worst ? STACK_DEPTH + 1 : $urandom_range(1, STACK_DEPTH + 2);
        repeat (count) begin
          send_packet(OP_CALL, 24'($urandom));
          if (!worst && $urandom_range(3) == 0) send_packet(pick_command(), 24'($urandom));
        end
        repeat (count + $urandom_range(0, 1) + int'(worst))
          send_packet(OP_RET, 24'($urandom));
      end
      SEQ_NOPS: begin
        count = worst ? NOP_LIMIT + 3 : $urandom_range(1, NOP_LIMIT + 5);
        repeat (count) send_packet(OP_NOP, 24'($urandom));
        send_packet(pick_command(), 24'($urandom));
      end
      SEQ_ENDING: begin
        repeat ($urandom_range(2, 6)) begin
          case ($urandom_range(2))
            0:       send_packet(OP_END, 24'($urandom));
            1:       send_packet(OP_FINISH, 24'($urandom));
            default: send_packet(OP_FINISH_ALT, 24'($urandom));
          endcase
        end
      end
      SEQ_ADDRESS: begin
        send_packet(OP_BASE, 24'($urandom));
        repeat ($urandom_range(1, 4)) begin
          case ($urandom_range(2))
            0:       send_packet(OP_JUMP, 24'($urandom));
            1:       send_packet(OP_VADDR, 24'($urandom));
            default: send_packet(OP_IADDR, 24'($urandom));
          endcase
        end
      end
      default: send_packet(8'($urandom), 24'($urandom));
    endcase
  endtask

  initial begin
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = REG_START;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    tracker       = new();

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    set_idling(12, 82);

    // Pointer and stall address both come out of reset at zero, so these
    // two packets are stalled and must leave the state untouched.
    send_packet(OP_NOP, 24'h000000);
    send_packet(OP_CALL, 24'hFFFFFF);

    // An unaligned stall address never matches. Starting at the top of the
    // address space makes the first advance wrap to zero.
    write_reg(REG_STALL, 32'hFFFF_FFFF);
    write_reg(REG_START, 32'hFFFF_FFFF);

    send_packet(OP_VADDR, 24'hFFFFFF);
    send_packet(OP_BASE, 24'hFFFFFF);
    send_packet(OP_IADDR, 24'h000000);
    // Jump target is the base ORed with the argument, low bits dropped.
    send_packet(OP_JUMP, 24'h0000FF);
    // The call from the last word pushes a wrapped return address of zero.
    send_packet(OP_CALL, 24'h000000);
    send_packet(OP_RET, 24'h000000);
    // Return with an empty stack is a stack error.
    send_packet(OP_RET, 24'hFFFFFF);
    send_packet(OP_BASE, 24'h000000);
    // END pauses before a FINISH and reports done after one.
    send_packet(OP_END, 24'h123456);
    send_packet(OP_FINISH, 24'h000000);
    send_packet(OP_END, 24'hFFFFFF);
    send_packet(OP_FINISH_ALT, 24'h000001);
    send_packet(OP_SIGNAL, 24'hABCDEF);
    send_packet(8'hFF, 24'hFFFFFF);
    send_packet(8'hAA, 24'h555555);
    send_packet(8'h55, 24'hAAAAAA);
    send_packet(OP_NOP, 24'h000000);

    // One sequence of every shape pushed into its corner case first.
    for (int k = 0; k < SEQ_COUNT; k++) send_sequence(seq_kind_e'(k), 1'b1);

    // Random part in segments. Each segment starts from an idle block with
    // a fresh idling mode, a new stall address and, in three of four segments,
    // a new start address; two in five place the stall address 3 to 24 words
    // ahead of the pointer so the list runs into it.
    while (tracker.packet_count < ITEM_TARGET) begin
      s_axis_tvalid <= 1'b0;
      drain();
      if (tracker.packet_count < ITEM_TARGET / 3) begin
        set_idling(12, 82);
      end else if (tracker.packet_count < 2 * ITEM_TARGET / 3) begin
        set_idling(82, 12);
      end else begin
        set_idling(0, 0);
        hold_req <= 1'b1;
      end
      case ($urandom_range(3))
        0:       write_reg(REG_START, 32'h0000_0000);
        1:       write_reg(REG_START, 32'hFFFF_FFFF);
        2:       write_reg(REG_START, $urandom);
        default: ;  // the list keeps running with its stack and flags
      endcase
      case ($urandom_range(4))
        0, 1:    write_reg(REG_STALL, tracker.fetch_ptr + 32'(4 * $urandom_range(3, 24)));
        2:       write_reg(REG_STALL, 32'hFFFF_FFFF);
        3:       write_reg(REG_STALL, 32'h0000_0000);
        default: write_reg(REG_STALL, $urandom);
      endcase
      sent_in_seg = 0;
      while (sent_in_seg < SEG_ITEMS)
        send_sequence(seq_kind_e'($urandom_range(SEQ_COUNT - 1)), 1'b0);
    end

    s_axis_tvalid <= 1'b0;
    drain();
    repeat (4) @(posedge clk_i);
    if (tracker.failures == 0 && tracker.pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[files.f]
src/dls_pkg.sv
src/dls_stack.sv
src/display_list_sequencer.sv
dv/display_list_sequencer_tb.sv
